// ----- sv/assert_macros.svh -----
// Assertion macros shared by the confusion metrics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on clk_i, switched off while rst_ni is low.
`define SCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on clk_i at every edge, reset included.
`define SCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/scm_pkg.sv -----
// Shared types, constants and microcode table of the confusion metrics unit.
`timescale 1ns / 1ps

package scm_pkg;

  // Defaults for the top-level parameters
  localparam longint unsigned MAX_PIXELS_DEF = 64'd16777216;
  localparam int unsigned     RATIO_BITS_DEF = 16;

  // Pixel channel format
  localparam int unsigned PIXEL_W  = 8;
  localparam logic [PIXEL_W-1:0] DARK_THRESHOLD_RESET = 8'd20;
  localparam logic [PIXEL_W-1:0] MARK_RED             = 8'd255;
  localparam logic [PIXEL_W-1:0] MARK_ZERO            = 8'd0;

  // Ratio slots, in output order
  localparam int unsigned NUM_RATIOS = 4;
  localparam int unsigned RIDX_W     = 2;
  localparam logic [RIDX_W-1:0] R_PRECISION   = 2'd0;
  localparam logic [RIDX_W-1:0] R_SPECIFICITY = 2'd1;
  localparam logic [RIDX_W-1:0] R_SENSITIVITY = 2'd2;
  localparam logic [RIDX_W-1:0] R_ACCURACY    = 2'd3;

  // Microprogram addresses
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SETUP = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ITER  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_STORE = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

  // Datapath operation of one step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SETUP,
    OP_ITER,
    OP_STORE,
    OP_EMIT
  } op_e;

  // Branch conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_ITER_MORE,
    C_RATIO_MORE,
    C_OUT_BUSY
  } cond_e;

  // One control word: hold on this step while hold is true, else jump to
  // target while jump is true, else advance
  typedef struct packed {
    op_e               op;
    cond_e             hold;
    cond_e             jump;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  // Status fed back from the datapath to the sequencer
  typedef struct packed {
    logic iter_more;
    logic ratio_more;
    logic out_busy;
  } dp_status_t;

  // Microprogram ROM
  function automatic ctl_word_t ucode(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '{op: OP_IDLE, hold: C_NEVER, jump: C_NEVER, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.op   = OP_IDLE;
        w.hold = C_NO_START;
      end
      STEP_LOAD: begin
        w.op = OP_LOAD;
      end
      STEP_SETUP: begin
        w.op = OP_SETUP;
      end
      STEP_ITER: begin
        w.op   = OP_ITER;
        w.hold = C_ITER_MORE;
      end
      STEP_STORE: begin
        w.op     = OP_STORE;
        w.jump   = C_RATIO_MORE;
        w.target = STEP_SETUP;
      end
      STEP_EMIT: begin
        w.op     = OP_EMIT;
        w.hold   = C_OUT_BUSY;
        w.jump   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jump   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/scm_sequencer.sv -----
// Step counter and microcode fetch with conditional hold and jump.
`timescale 1ns / 1ps

module scm_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  scm_pkg::dp_status_t  status_i,
  output scm_pkg::ctl_word_t   ctl_o
);

  logic [scm_pkg::STEP_W-1:0] step_q, step_d;
  scm_pkg::ctl_word_t         word;
  logic                       hold_hit, jump_hit;

  function automatic logic eval_cond(input scm_pkg::cond_e c,
                                     input logic start,
                                     input scm_pkg::dp_status_t st);
    logic r;
    case (c)
      scm_pkg::C_NEVER:      r = 1'b0;
      scm_pkg::C_ALWAYS:     r = 1'b1;
      scm_pkg::C_NO_START:   r = !start;
      scm_pkg::C_ITER_MORE:  r = st.iter_more;
      scm_pkg::C_RATIO_MORE: r = st.ratio_more;
      scm_pkg::C_OUT_BUSY:   r = st.out_busy;
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  // Fetch the control word of the current step
  assign word  = scm_pkg::ucode(step_q);
  assign ctl_o = word;

  // Pick the next step
  always_comb begin
    hold_hit = eval_cond(word.hold, start_i, status_i);
    jump_hit = eval_cond(word.jump, start_i, status_i);
    if (hold_hit) begin
      step_d = step_q;
    end else if (jump_hit) begin
      step_d = word.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= scm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- sv/scm_datapath.sv -----
// Count snapshot, shared restoring divider and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scm_datapath #(
  parameter longint unsigned MAX_PIXELS = scm_pkg::MAX_PIXELS_DEF,
  parameter int unsigned     RATIO_BITS = scm_pkg::RATIO_BITS_DEF,
  localparam int unsigned    CNT_W      = $clog2(MAX_PIXELS + 1),
  localparam int unsigned    USED_W     = 4 * (CNT_W + RATIO_BITS),
  localparam int unsigned    TDATA_W    = ((USED_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  scm_pkg::ctl_word_t          ctl_i,
  input  logic [CNT_W-1:0]            tp_i,
  input  logic [CNT_W-1:0]            tn_i,
  input  logic [CNT_W-1:0]            fp_i,
  input  logic [CNT_W-1:0]            fn_i,
  output scm_pkg::dp_status_t         status_o,
  input  logic                        m_axis_tready_i,
  output logic                        m_axis_tvalid_o,
  output logic [TDATA_W-1:0]          m_axis_tdata_o,
  output logic [scm_pkg::NUM_RATIOS-1:0] m_axis_tuser_o
);

  localparam int unsigned NUM_W  = CNT_W + 1;
  localparam int unsigned DEN_W  = CNT_W + 2;
  localparam int unsigned ITER_W = $clog2(RATIO_BITS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(RATIO_BITS - 1);
  localparam logic [RATIO_BITS-1:0] RATIO_SAT = {RATIO_BITS{1'b1}};

  // Snapshot of the counts
  logic [CNT_W-1:0] tp_q, tn_q, fp_q, fn_q;

  // Divider state
  logic [scm_pkg::RIDX_W-1:0] idx_q, idx_d;
  logic [ITER_W-1:0]          iter_q, iter_d;
  logic [DEN_W-1:0]           rem_q, rem_d;
  logic [DEN_W-1:0]           den_q, den_d;
  logic [RATIO_BITS-1:0]      quo_q, quo_d;
  logic                       special_q, special_d;

  // Finished ratios and zero-denominator flags
  logic [RATIO_BITS-1:0]             ratio_q [scm_pkg::NUM_RATIOS];
  logic [scm_pkg::NUM_RATIOS-1:0]    flags_q;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic [TDATA_W-1:0]             out_data_q;
  logic [scm_pkg::NUM_RATIOS-1:0] out_user_q;

  // Operand selection for the current ratio
  logic [NUM_W-1:0]   sum_tp_fp, sum_tn_fp, sum_tp_fn, sum_tp_tn, sum_fp_fn;
  logic [NUM_W-1:0]   num_sel;
  logic [DEN_W-1:0]   den_sel;
  logic [DEN_W:0]     rem_dbl;
  logic               den_zero, num_ge_den;

  always_comb begin
    sum_tp_fp = {1'b0, tp_q} + {1'b0, fp_q};
    sum_tn_fp = {1'b0, tn_q} + {1'b0, fp_q};
    sum_tp_fn = {1'b0, tp_q} + {1'b0, fn_q};
    sum_tp_tn = {1'b0, tp_q} + {1'b0, tn_q};
    sum_fp_fn = {1'b0, fp_q} + {1'b0, fn_q};
    case (idx_q)
      scm_pkg::R_PRECISION: begin
        num_sel = {1'b0, tp_q};
        den_sel = {1'b0, sum_tp_fp};
      end
      scm_pkg::R_SPECIFICITY: begin
        num_sel = {1'b0, tn_q};
        den_sel = {1'b0, sum_tn_fp};
      end
      scm_pkg::R_SENSITIVITY: begin
        num_sel = {1'b0, tp_q};
        den_sel = {1'b0, sum_tp_fn};
      end
      default: begin
        num_sel = sum_tp_tn;
        den_sel = {1'b0, sum_tp_tn} + {1'b0, sum_fp_fn};
      end
    endcase
    den_zero   = (den_sel == '0);
    num_ge_den = ({1'b0, num_sel} >= den_sel);
    rem_dbl    = {rem_q, 1'b0};
  end

  // Divider control and arithmetic
  always_comb begin
    idx_d     = idx_q;
    iter_d    = iter_q;
    rem_d     = rem_q;
    den_d     = den_q;
    quo_d     = quo_q;
    special_d = special_q;
    case (ctl_i.op)
      scm_pkg::OP_LOAD: begin
        idx_d = scm_pkg::R_PRECISION;
      end
      scm_pkg::OP_SETUP: begin
        iter_d    = '0;
        rem_d     = {1'b0, num_sel};
        den_d     = den_sel;
        special_d = den_zero || num_ge_den;
        quo_d     = (!den_zero && num_ge_den) ? RATIO_SAT : '0;
      end
      scm_pkg::OP_ITER: begin
        iter_d = iter_q + 1'b1;
        if (!special_q) begin
          if (rem_dbl >= {1'b0, den_q}) begin
            rem_d = DEN_W'(rem_dbl - {1'b0, den_q});
            quo_d = {quo_q[RATIO_BITS-2:0], 1'b1};
          end else begin
            rem_d = rem_dbl[DEN_W-1:0];
            quo_d = {quo_q[RATIO_BITS-2:0], 1'b0};
          end
        end
      end
      scm_pkg::OP_STORE: begin
        idx_d = idx_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= scm_pkg::R_PRECISION;
      iter_q <= '0;
    end else begin
      idx_q  <= idx_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    den_q     <= den_d;
    quo_q     <= quo_d;
    special_q <= special_d;
  end

  // Capture counts, ratios and flags
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == scm_pkg::OP_LOAD) begin
      tp_q <= tp_i;
      tn_q <= tn_i;
      fp_q <= fp_i;
      fn_q <= fn_i;
    end
    if (ctl_i.op == scm_pkg::OP_SETUP) begin
      flags_q[idx_q] <= den_zero;
    end
    if (ctl_i.op == scm_pkg::OP_STORE) begin
      ratio_q[idx_q] <= quo_q;
    end
  end

  // Load the output register when it is free, drop valid when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_i.op == scm_pkg::OP_EMIT && !out_valid_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == scm_pkg::OP_EMIT && !out_valid_q) begin
      out_data_q <= TDATA_W'({ratio_q[scm_pkg::R_ACCURACY],
                              ratio_q[scm_pkg::R_SENSITIVITY],
                              ratio_q[scm_pkg::R_SPECIFICITY],
                              ratio_q[scm_pkg::R_PRECISION],
                              fn_q, fp_q, tn_q, tp_q});
      out_user_q <= flags_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Status back to the sequencer
  assign status_o.iter_more  = (iter_q != ITER_LAST);
  assign status_o.ratio_more = (idx_q != scm_pkg::R_ACCURACY);
  assign status_o.out_busy   = out_valid_q;

  // Checks
  `SCM_ASSERT(a_rem_below_den,
    ((ctl_i.op == scm_pkg::OP_ITER) && !special_q) |-> (rem_q < den_q),
    "divider remainder not below denominator")
  `SCM_ASSERT(a_flag_gives_zero,
    $rose(out_valid_q) |->
      ((!out_user_q[scm_pkg::R_PRECISION] || out_data_q[4*CNT_W +: RATIO_BITS] == '0) &&
       (!out_user_q[scm_pkg::R_ACCURACY] ||
        out_data_q[4*CNT_W + 3*RATIO_BITS +: RATIO_BITS] == '0)),
    "flagged ratio is not zero")

endmodule

// ----- sv/segmentation_confusion_metrics_unit.sv -----
// Top level of the segmentation confusion metrics unit.
//
// Input stream s_axis carries one pixel pair per item (predicted and reference
// BGR pixel in tdata); tlast marks the last pixel of an image. Pixels whose
// predicted channels are all below the dark threshold are not counted.
// The threshold is written through cfg_we_i/cfg_wdata_i; the user must do so
// only while the unit idles, as the block does not enforce it. Ordinary pixels
// are taken one per cycle while the unit idles, each bumping one of four
// saturating counters. The last pixel starts a microprogram that snapshots
// and clears the counters and runs four ratios through one shared restoring
// divider, one quotient bit per cycle; the result is then registered on m_axis,
// and s_axis_tready_o stays low until the program is back at its idle step.
// The result waits in the output register while m_axis_tready_i is low;
// pixels of the next image are counted meanwhile, and the next last pixel's
// program holds at its emit step until the register is free.
// Reset clears the counters, sets the threshold to 20 and empties the output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segmentation_confusion_metrics_unit #(
  parameter longint unsigned MAX_PIXELS = scm_pkg::MAX_PIXELS_DEF,
  parameter int unsigned     RATIO_BITS = scm_pkg::RATIO_BITS_DEF,
  localparam int unsigned    CNT_W      = $clog2(MAX_PIXELS + 1),
  localparam int unsigned    USED_W     = 4 * (CNT_W + RATIO_BITS),
  localparam int unsigned    TDATA_W    = ((USED_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Dark threshold register
  input  logic                           cfg_we_i,
  input  logic [scm_pkg::PIXEL_W-1:0]    cfg_wdata_i,
  // Pixel stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // pred_blue, pred_green, pred_red, ref_blue, ref_green, ref_red
  input  logic [6*scm_pkg::PIXEL_W-1:0]  s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,   // last_pixel
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // true_pos, true_neg, false_pos, false_neg, precision_q16,
  // specificity_q16, sensitivity_q16, accuracy_q16, zero pad
  output logic [TDATA_W-1:0]             m_axis_tdata_o,
  // undefined_flags
  output logic [scm_pkg::NUM_RATIOS-1:0] m_axis_tuser_o
);

  localparam int unsigned PW = scm_pkg::PIXEL_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  logic [PW-1:0]  thresh_q;
  logic [CNT_W-1:0] tp_q, tn_q, fp_q, fn_q;
  logic [CNT_W-1:0] tp_d, tn_d, fp_d, fn_d;

  scm_pkg::ctl_word_t  ctl;
  scm_pkg::dp_status_t status;

  logic [PW-1:0] pred_b, pred_g, pred_r, ref_b, ref_g, ref_r;
  logic          in_hs, start, dark, pred_mark, ref_mark;

  // Unpack the pixel pair
  assign pred_b = s_axis_tdata_i[0*PW +: PW];
  assign pred_g = s_axis_tdata_i[1*PW +: PW];
  assign pred_r = s_axis_tdata_i[2*PW +: PW];
  assign ref_b  = s_axis_tdata_i[3*PW +: PW];
  assign ref_g  = s_axis_tdata_i[4*PW +: PW];
  assign ref_r  = s_axis_tdata_i[5*PW +: PW];

  assign s_axis_tready_o = (ctl.op == scm_pkg::OP_IDLE);
  assign in_hs           = s_axis_tvalid_i && s_axis_tready_o;
  assign start           = in_hs && s_axis_tlast_i;

  // Classify the pair
  assign dark      = (pred_b < thresh_q) && (pred_g < thresh_q) && (pred_r < thresh_q);
  assign pred_mark = (pred_b == scm_pkg::MARK_ZERO) && (pred_g == scm_pkg::MARK_ZERO) &&
                     (pred_r == scm_pkg::MARK_RED);
  assign ref_mark  = (ref_b == scm_pkg::MARK_ZERO) && (ref_g == scm_pkg::MARK_ZERO) &&
                     (ref_r == scm_pkg::MARK_RED);

  // Bump one saturating counter per counted pixel, clear on snapshot
  always_comb begin
    tp_d = tp_q;
    tn_d = tn_q;
    fp_d = fp_q;
    fn_d = fn_q;
    if (ctl.op == scm_pkg::OP_LOAD) begin
      tp_d = '0;
      tn_d = '0;
      fp_d = '0;
      fn_d = '0;
    end else if (in_hs && !dark) begin
      if (pred_mark && ref_mark) begin
        if (tp_q < CNT_MAX) tp_d = tp_q + 1'b1;
      end else if (pred_mark) begin
        if (fp_q < CNT_MAX) fp_d = fp_q + 1'b1;
      end else if (!ref_mark) begin
        if (tn_q < CNT_MAX) tn_d = tn_q + 1'b1;
      end else begin
        if (fn_q < CNT_MAX) fn_d = fn_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q <= '0;
      tn_q <= '0;
      fp_q <= '0;
      fn_q <= '0;
    end else begin
      tp_q <= tp_d;
      tn_q <= tn_d;
      fp_q <= fp_d;
      fn_q <= fn_d;
    end
  end

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= scm_pkg::DARK_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  scm_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .ctl_o    (ctl)
  );

  scm_datapath #(
    .MAX_PIXELS (MAX_PIXELS),
    .RATIO_BITS (RATIO_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .tp_i            (tp_q),
    .tn_i            (tn_q),
    .fp_i            (fp_q),
    .fn_i            (fn_q),
    .status_o        (status),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Checks
  `SCM_ASSERT(a_clear_after_load,
    (ctl.op == scm_pkg::OP_LOAD) |=>
      (tp_q == '0 && tn_q == '0 && fp_q == '0 && fn_q == '0),
    "counters not cleared after snapshot")
  `SCM_ASSERT_ALWAYS(a_count_bounded,
    (!rst_ni || (tp_q <= CNT_MAX && tn_q <= CNT_MAX && fp_q <= CNT_MAX && fn_q <= CNT_MAX)),
    "counter above saturation limit")

endmodule

// ----- bench/segmentation_confusion_metrics_unit_test.sv -----
// Self-checking testbench for the segmentation confusion metrics unit.
`timescale 1ns / 1ps

module segmentation_confusion_metrics_unit_test;

  localparam int unsigned CNT_W   = 25;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned FLAGS_W = scm_pkg::NUM_RATIOS;

  // One pixel pair, last field in the lowest bits
  typedef struct packed {
    logic [7:0] ref_red;
    logic [7:0] ref_green;
    logic [7:0] ref_blue;
    logic [7:0] pred_red;
    logic [7:0] pred_green;
    logic [7:0] pred_blue;
  } pixel_pair_t;

  // Result tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [3:0]       pad;
    logic [Q_W-1:0]   accuracy;
    logic [Q_W-1:0]   sensitivity;
    logic [Q_W-1:0]   specificity;
    logic [Q_W-1:0]   precision;
    logic [CNT_W-1:0] false_neg;
    logic [CNT_W-1:0] false_pos;
    logic [CNT_W-1:0] true_neg;
    logic [CNT_W-1:0] true_pos;
  } metrics_t;

  typedef struct {
    metrics_t             data;
    logic [FLAGS_W-1:0]   flags;
  } image_metrics_t;

  // Tracks confusion counts per image and checks the emitted metrics
  class metrics_scoreboard;
    logic [7:0]       dark_threshold;
    longint unsigned  tp_cnt, tn_cnt, fp_cnt, fn_cnt;
    image_metrics_t   pending_q[$];
    int unsigned      errors, images_checked, pixels_seen, pixels_skipped;

    function new();
      dark_threshold = scm_pkg::DARK_THRESHOLD_RESET;
      tp_cnt = 0; tn_cnt = 0; fp_cnt = 0; fn_cnt = 0;
      errors = 0; images_checked = 0; pixels_seen = 0; pixels_skipped = 0;
    endfunction

    function bit is_marked(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      return b == scm_pkg::MARK_ZERO && g == scm_pkg::MARK_ZERO && r == scm_pkg::MARK_RED;
    endfunction

    function longint unsigned bumped(longint unsigned c);
      return (c < scm_pkg::MAX_PIXELS_DEF) ? c + 1 : c;
    endfunction

    // Q0.16 fraction, saturated; zero denominator gives 0 and raises the flag
    function logic [Q_W-1:0] fraction(longint unsigned num, longint unsigned den,
                                      output bit undef);
      undef = (den == 0);
      if (den == 0) return '0;
      if (num >= den) return '1;
      return Q_W'((num << Q_W) / den);
    endfunction

    // Note an accepted pixel pair and queue the metrics on the last one
    function void note_pixel(pixel_pair_t p, bit last);
      bit dark, pm, rm, u0, u1, u2, u3;
      image_metrics_t m;
      pixels_seen++;
      dark = p.pred_blue < dark_threshold && p.pred_green < dark_threshold &&
             p.pred_red < dark_threshold;
      if (dark) begin
        pixels_skipped++;
      end else begin
        pm = is_marked(p.pred_blue, p.pred_green, p.pred_red);
        rm = is_marked(p.ref_blue, p.ref_green, p.ref_red);
        if (pm && rm)  tp_cnt = bumped(tp_cnt);
        else if (pm)   fp_cnt = bumped(fp_cnt);
        else if (!rm)  tn_cnt = bumped(tn_cnt);
        else           fn_cnt = bumped(fn_cnt);
      end
      if (!last) return;
      m.data             = '0;
      m.data.true_pos    = CNT_W'(tp_cnt);
      m.data.true_neg    = CNT_W'(tn_cnt);
      m.data.false_pos   = CNT_W'(fp_cnt);
      m.data.false_neg   = CNT_W'(fn_cnt);
      m.data.precision   = fraction(tp_cnt, tp_cnt + fp_cnt, u0);
      m.data.specificity = fraction(tn_cnt, tn_cnt + fp_cnt, u1);
      m.data.sensitivity = fraction(tp_cnt, tp_cnt + fn_cnt, u2);
      m.data.accuracy    = fraction(tp_cnt + tn_cnt,
                                    tp_cnt + tn_cnt + fp_cnt + fn_cnt, u3);
      m.flags = '0;
      m.flags[scm_pkg::R_PRECISION]   = u0;
      m.flags[scm_pkg::R_SPECIFICITY] = u1;
      m.flags[scm_pkg::R_SENSITIVITY] = u2;
      m.flags[scm_pkg::R_ACCURACY]    = u3;
      pending_q.insert(pending_q.size(), m);
      tp_cnt = 0; tn_cnt = 0; fp_cnt = 0; fn_cnt = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task compare(string field, longint unsigned got, longint unsigned want);
      if (got != want) report($sformatf("image %0d %s: got %0d, expected %0d",
                                        images_checked, field, got, want));
    endtask

    // Check one accepted result against the oldest pending image
    task check_result(metrics_t got, logic [FLAGS_W-1:0] got_flags);
      image_metrics_t want;
      if (pending_q.size() == 0) begin
        report("result arrived with no image pending");
        return;
      end
      want = pending_q.pop_front();
      compare("true_pos",        got.true_pos,    want.data.true_pos);
      compare("true_neg",        got.true_neg,    want.data.true_neg);
      compare("false_pos",       got.false_pos,   want.data.false_pos);
      compare("false_neg",       got.false_neg,   want.data.false_neg);
      compare("precision_q16",   got.precision,   want.data.precision);
      compare("specificity_q16", got.specificity, want.data.specificity);
      compare("sensitivity_q16", got.sensitivity, want.data.sensitivity);
      compare("accuracy_q16",    got.accuracy,    want.data.accuracy);
      compare("undefined_flags", got_flags,       want.flags);
      images_checked++;
    endtask
  endclass

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            cfg_we      = 1'b0;
  logic [scm_pkg::PIXEL_W-1:0]     cfg_wdata   = '0;
  logic                            s_tvalid    = 1'b0;
  logic                            s_tready;
  pixel_pair_t                     s_tdata     = '0;
  logic                            s_tlast     = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready    = 1'b0;
  metrics_t                        m_tdata;
  logic [FLAGS_W-1:0]              m_tuser;

  metrics_scoreboard sb = new();
  bit                sender_eager = 1'b0;

  segmentation_confusion_metrics_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("Timeout: stimulus or results stalled");
    $display("Regression FAIL");
    $finish;
  end

  function automatic pixel_pair_t pair(logic [7:0] pb, logic [7:0] pg, logic [7:0] pr,
                                       logic [7:0] rb, logic [7:0] rg, logic [7:0] rr);
    return '{ref_red: rr, ref_green: rg, ref_blue: rb,
             pred_red: pr, pred_green: pg, pred_blue: pb};
  endfunction

  // Random pixel pair, biased toward marked, dark and nearly marked pixels
  function automatic pixel_pair_t random_pair(logic [7:0] thr);
    logic [23:0] red_rgb, pred_rgb, ref_rgb;
    int unsigned pk, rk;
    red_rgb  = {scm_pkg::MARK_RED, scm_pkg::MARK_ZERO, scm_pkg::MARK_ZERO};
    pred_rgb = 24'($urandom);
    ref_rgb  = 24'($urandom);
    pk = $urandom_range(0, 9);
    rk = $urandom_range(0, 9);
    if (pk < 3) pred_rgb = red_rgb;
    else if (pk < 5 && thr != 0)
      pred_rgb = {8'($urandom_range(0, thr - 1)), 8'($urandom_range(0, thr - 1)),
                  8'($urandom_range(0, thr - 1))};
    else if (pk == 5) pred_rgb = red_rgb ^ (24'd1 << $urandom_range(0, 23));
    if (rk < 4) ref_rgb = red_rgb;
    else if (rk == 4) ref_rgb = red_rgb ^ (24'd1 << $urandom_range(0, 23));
    return {ref_rgb, pred_rgb};
  endfunction

  // Offer one pixel pair and hold it until taken
  task automatic send_pixel(pixel_pair_t p, bit last);
    int unsigned gap;
    gap = sender_eager ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(p, last);
  endtask

  // Hold the stream until every pending image has reported
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Write the threshold once the unit is back to idle
  task automatic write_threshold(logic [7:0] value);
    wait_drain();
    repeat (100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.dark_threshold = value;
  endtask

  // Result side: random stalls with stretches of none
  initial begin
    int unsigned stall;
    bit          eager;
    eager = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) eager = !eager;
      stall = eager ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata, m_tuser);
    end
  end

  // Stimulus
  initial begin
    logic [7:0]  thr_list [6];
    int unsigned budget, len;
    thr_list = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd1,
                 8'($urandom_range(1, 254)), scm_pkg::DARK_THRESHOLD_RESET};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    // Dark last pixel alone: nothing counted, every ratio undefined
    send_pixel(pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255), 1'b1);
    // Single hit: ratios saturate at full scale, but specificity is undefined
    send_pixel(pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255), 1'b1);
    // All four outcomes, ended by a skipped dark pixel
    send_pixel(pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
    send_pixel(pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd19, 8'd19, 8'd19, 8'd0, 8'd0, 8'd255), 1'b1);
    // Nearly marked pixels and the threshold boundary
    send_pixel(pair(8'd1, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd0, 8'd0, 8'd254, 8'd0, 8'd1, 8'd255), 1'b0);
    send_pixel(pair(8'd20, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd0, 8'd0, 8'd19, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255), 1'b1);
    // False positive alone: zero ratios next to an undefined one
    send_pixel(pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255), 1'b1);
    // Threshold zero: black pixel is counted
    write_threshold(8'd0);
    send_pixel(pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1);
    // Threshold at top: only pixels with a channel at 255 are counted
    write_threshold(8'd255);
    send_pixel(pair(8'd254, 8'd254, 8'd254, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd254, 8'd254, 8'd255, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255), 1'b1);

    // Random images under several thresholds
    foreach (thr_list[i]) begin
      write_threshold(thr_list[i]);
      budget = 85;
      while (budget > 0) begin
        sender_eager = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) wait_drain();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        if (len > budget) len = budget;
        for (int unsigned k = 1; k <= len; k++)
          send_pixel(random_pair(sb.dark_threshold), k == len);
        budget -= len;
      end
    end
    sender_eager = 1'b0;

    // Drain and let any stray result show up
    wait_drain();
    repeat (120) @(posedge clk);
    $display("Checked %0d images from %0d pixel pairs, %0d skipped as dark,",
             sb.images_checked, sb.pixels_seen, sb.pixels_skipped);
    $display("over thresholds 0, 1, 20, 255 and two random values.");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
